// ===== hw/rtl/sdpg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared types and constants for the step/direction pulse generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdpg_pkg;

  localparam int LINE_COUNT      = 15;
  localparam int STEP_COUNT_BITS = 21;

  localparam int LINE_W     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int HALF_W     = 10;
  localparam int ACT_W      = 5;
  localparam int LEN_W      = 16;
  localparam int RAW_CNT_W  = 22;
  localparam int CNT_CALC_W = (STEP_COUNT_BITS > RAW_CNT_W) ? STEP_COUNT_BITS : RAW_CNT_W;

  localparam int PORT_LINES = 15;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // half periods in microsecond ticks
  localparam logic [HALF_W-1:0] HALF_JOG    = HALF_W'(80);
  localparam logic [HALF_W-1:0] HALF_FAST   = HALF_W'(8);
  localparam logic [HALF_W-1:0] HALF_SLOW   = HALF_W'(800);
  localparam logic [HALF_W-1:0] HALF_MID    = HALF_W'(20);
  localparam logic [HALF_W-1:0] HALF_EXTRA  = HALF_W'(500);

  // actuator numbers with special handling
  localparam logic [ACT_W-1:0] ACT_FIRST      = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_LAST_FAST  = ACT_W'(12);
  localparam logic [ACT_W-1:0] ACT_SLOW       = ACT_W'(13);
  localparam logic [ACT_W-1:0] ACT_LAST_PLAIN = ACT_W'(15);
  localparam logic [ACT_W-1:0] ACT_FIRST_XTRA = ACT_W'(16);
  localparam logic [ACT_W-1:0] ACT_LAST_XTRA  = ACT_W'(17);
  localparam logic [ACT_W-1:0] XTRA_LINE_OFS  = ACT_W'(10);

  // ceil(2^18 / 3), exact floor division by three for values below 2^17
  localparam int RECIP3_SHIFT = 18;
  localparam logic [33:0] RECIP3 = 34'd87382;

  localparam logic [CNT_CALC_W-1:0] STEP_MAX =
    CNT_CALC_W'((64'd1 << STEP_COUNT_BITS) - 64'd1);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic                       dir;
    logic                       ok;
    logic [LINE_W-1:0]          line;
    logic [STEP_COUNT_BITS-1:0] count;
    logic [HALF_W-1:0]          half;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdpg_cmd_decode.sv =====
// ----------------------------------------------------------------------------
// sdpg_cmd_decode
// Turns a raw move command into line index, step count and half period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdpg_cmd_decode
  import sdpg_pkg::*;
(
  input  wire logic             operation,
  input  wire logic [LEN_W-1:0] length_q4,
  input  wire logic             direction,
  input  wire logic [ACT_W-1:0] actuator,
  input  wire logic             jog_mode,
  output cmd_t                  cmd
);

  logic [ACT_W-1:0]      line_raw;
  logic                  act_ok;
  logic [LEN_W:0]        twice_len;
  logic [33:0]           third_prod;
  logic [LEN_W-1:0]      third;
  logic [RAW_CNT_W-1:0]  n_norm;
  logic [RAW_CNT_W-1:0]  n_slow_full;
  logic [RAW_CNT_W-1:0]  n_raw;
  logic [CNT_CALC_W-1:0] n_ext;
  logic [HALF_W-1:0]     half;

  always_comb begin
    line_raw = (actuator >= ACT_FIRST_XTRA) ? actuator - XTRA_LINE_OFS : actuator - ACT_FIRST;
    act_ok   = (actuator >= ACT_FIRST) &&
               (jog_mode ? (actuator <= ACT_LAST_PLAIN) : (actuator <= ACT_LAST_XTRA)) &&
               ({1'b0, line_raw} < 6'(LINE_COUNT));
  end

  // 50*len/3 = 16*len + floor(2*len/3)
  always_comb begin
    twice_len   = {length_q4, 1'b0};
    third_prod  = 34'(twice_len) * RECIP3;
    third       = third_prod[RECIP3_SHIFT +: LEN_W];
    n_norm      = (RAW_CNT_W'(length_q4) << 4) + RAW_CNT_W'(third);
    n_slow_full = RAW_CNT_W'(length_q4) * RAW_CNT_W'(25);
    n_raw       = (actuator == ACT_SLOW) ? (n_slow_full >> 1) : n_norm;
    n_ext       = CNT_CALC_W'(n_raw);
  end

  always_comb begin
    if (jog_mode) begin
      half = HALF_JOG;
    end else if (actuator <= ACT_LAST_FAST) begin
      half = HALF_FAST;
    end else if (actuator == ACT_SLOW) begin
      half = HALF_SLOW;
    end else if (actuator <= ACT_LAST_PLAIN) begin
      half = HALF_MID;
    end else begin
      half = HALF_EXTRA;
    end
  end

  always_comb begin
    cmd.op    = op_t'(operation);
    cmd.dir   = direction;
    cmd.ok    = act_ok;
    cmd.line  = LINE_W'(line_raw);
    cmd.count = (n_ext > STEP_MAX) ? STEP_MAX[STEP_COUNT_BITS-1:0]
                                   : n_ext[STEP_COUNT_BITS-1:0];
    cmd.half  = half;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/step_dir_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step and direction line driver for a set of linear actuators.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis side: tuser picks a one-microsecond tick or a
// move command, tdata carries the command fields. Each accepted item gives
// exactly one result transfer on the m_axis side, holding the step and
// direction line levels after the item, the busy flag, a done flag on the
// item that ends a move and a rejected flag for a refused command.
// An item passes the input register, holding the decoded command, then the
// line state update feeding the result register. One item is taken per
// cycle while the receiver does not stall; the state update for one item is
// combinational, so ticks can stream back to back.
// Reset clears all lines, stops any move and empties both registers.
// When the receiver stalls the result register holds, the input register
// keeps one more item, and only then tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module step_dir_pulse_generator
  import sdpg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [15:0] length_q4, [16] direction, [21:17] actuator, [22] jog_mode
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  wire logic [0:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [14:0] step_lines, [29:15] dir_lines, [30] busy_res, [31] done_res, [32] rejected
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  cmd_t cmd_dec;
  cmd_t cmd;
  logic cmd_valid;
  logic out_free;
  logic proc;

  logic [LINE_COUNT-1:0]      step_levels, step_levels_next;
  logic [LINE_COUNT-1:0]      dir_levels, dir_levels_next;
  logic                       moving, moving_next;
  logic                       high_phase, high_phase_next;
  logic [HALF_W-1:0]          half_ticks_left, half_ticks_left_next;
  logic [HALF_W-1:0]          half_period_now, half_period_now_next;
  logic [STEP_COUNT_BITS-1:0] steps_left, steps_left_next;
  logic [LINE_W-1:0]          active_line, active_line_next;
  logic                       done_next, rej_next;

  logic [LINE_COUNT-1:0]      cmd_bit, act_bit;
  logic [HALF_W-1:0]          hl_dec;
  logic [STEP_COUNT_BITS-1:0] sl_dec;
  logic [31:0]                step_ext, dir_ext;
  logic [OUT_DATA_W-1:0]      out_data;

  sdpg_cmd_decode u_decode (
    .operation (s_axis_tuser[0]),
    .length_q4 (s_axis_tdata[15:0]),
    .direction (s_axis_tdata[16]),
    .actuator  (s_axis_tdata[21:17]),
    .jog_mode  (s_axis_tdata[22]),
    .cmd       (cmd_dec)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign proc          = cmd_valid && out_free;
  assign s_axis_tready = !cmd_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_axis_tready) begin
      cmd_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd <= cmd_dec;
    end
  end

  always_comb begin
    cmd_bit = LINE_COUNT'(1) << cmd.line;
    act_bit = LINE_COUNT'(1) << active_line;
    hl_dec  = (half_ticks_left != '0) ? half_ticks_left - HALF_W'(1) : '0;
    sl_dec  = (steps_left != '0) ? steps_left - STEP_COUNT_BITS'(1) : '0;

    step_levels_next     = step_levels;
    dir_levels_next      = dir_levels;
    moving_next          = moving;
    high_phase_next      = high_phase;
    half_ticks_left_next = half_ticks_left;
    half_period_now_next = half_period_now;
    steps_left_next      = steps_left;
    active_line_next     = active_line;
    done_next            = 1'b0;
    rej_next             = 1'b0;

    case (cmd.op)
      OP_MOVE: begin
        if (moving || !cmd.ok) begin
          rej_next = 1'b1;
        end else begin
          dir_levels_next  = cmd.dir ? (dir_levels | cmd_bit) : (dir_levels & ~cmd_bit);
          active_line_next = cmd.line;
          if (cmd.count == '0) begin
            done_next = 1'b1;
          end else begin
            steps_left_next      = cmd.count;
            half_period_now_next = cmd.half;
            half_ticks_left_next = cmd.half;
            high_phase_next      = 1'b0;
            moving_next          = 1'b1;
            step_levels_next     = step_levels & ~cmd_bit;
          end
        end
      end
      OP_TICK: begin
        if (moving) begin
          half_ticks_left_next = hl_dec;
          if (hl_dec == '0) begin
            if (!high_phase) begin
              step_levels_next     = step_levels | act_bit;
              high_phase_next      = 1'b1;
              half_ticks_left_next = half_period_now;
            end else begin
              steps_left_next = sl_dec;
              if (sl_dec == '0) begin
                moving_next     = 1'b0;
                high_phase_next = 1'b0;
                done_next       = 1'b1;
              end else begin
                step_levels_next     = step_levels & ~act_bit;
                high_phase_next      = 1'b0;
                half_ticks_left_next = half_period_now;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_levels     <= '0;
      dir_levels      <= '0;
      moving          <= 1'b0;
      high_phase      <= 1'b0;
      half_ticks_left <= '0;
      half_period_now <= '0;
      steps_left      <= '0;
      active_line     <= '0;
    end else if (proc) begin
      step_levels     <= step_levels_next;
      dir_levels      <= dir_levels_next;
      moving          <= moving_next;
      high_phase      <= high_phase_next;
      half_ticks_left <= half_ticks_left_next;
      half_period_now <= half_period_now_next;
      steps_left      <= steps_left_next;
      active_line     <= active_line_next;
    end
  end

  always_comb begin
    step_ext = 32'(step_levels_next);
    dir_ext  = 32'(dir_levels_next);
    out_data = OUT_DATA_W'({rej_next, done_next, moving_next,
                            dir_ext[PORT_LINES-1:0], step_ext[PORT_LINES-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_axis_tdata <= out_data;
    end
  end

  // a stopped generator never sits in its high half period
  assert property (@(posedge clk) disable iff (rst) !moving |-> !high_phase)
    else $error("high phase without a running move");

  // a running move always has pulses left and a nonzero half period
  assert property (@(posedge clk) disable iff (rst)
    moving |-> (steps_left != '0) && (half_period_now != '0) &&
               (half_ticks_left <= half_period_now))
    else $error("running move with inconsistent counters");

  // a result is never both done and rejected
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[31] && m_axis_tdata[32]))
    else $error("result marked done and rejected");

  // input side only backs up when the result register is stalled
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && cmd_valid)
    else $error("input stalled without a stalled result");

  // a rejected command leaves the line state untouched
  assert property (@(posedge clk) disable iff (rst)
    proc && rej_next |=> $stable(step_levels) && $stable(dir_levels) && $stable(moving))
    else $error("rejected command changed line state");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the step/direction pulse generator. A directed
// table covers reset levels, refused commands, zero-length moves, a busy
// refusal and a complete pulse train, then random move sequences follow,
// each ticked until its move ends or the item budget is spent, with commands
// thrown in mid-move. Every result transfer is checked field by field against
// an in-bench model of the line state, under random idling on both sides.
// ----------------------------------------------------------------------------

module tb;
  import sdpg_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int ITEM_TARGET = 950;
  localparam int HOLD_CYCLES = 120;
  localparam int PLAN_ROWS   = 15;

  typedef struct packed {
    logic [PORT_LINES-1:0] steps;
    logic [PORT_LINES-1:0] dirs;
    logic                  busy;
    logic                  done;
    logic                  rej;
  } line_state_t;

  typedef struct packed {
    op_t                op;
    logic [LEN_W-1:0]   len;
    logic               dir;
    logic [ACT_W-1:0]   act;
    logic               jog;
    logic [15:0]        reps;
    logic               typed;
    line_state_t        want;
  } plan_row_t;

  // op, len, dir, act, jog, reps, typed, {steps, dirs, busy, done, rej}
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{OP_TICK, 16'h0000, 1'b0, 5'd0,  1'b0, 16'd1, 1'b1, '{15'h0000, 15'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_MOVE, 16'hFFFF, 1'b1, 5'd0,  1'b0, 16'd1, 1'b1, '{15'h0000, 15'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_MOVE, 16'h8000, 1'b1, 5'd18, 1'b0, 16'd1, 1'b1, '{15'h0000, 15'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_MOVE, 16'h5555, 1'b0, 5'd31, 1'b1, 16'd1, 1'b1, '{15'h0000, 15'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_MOVE, 16'hAAAA, 1'b1, 5'd16, 1'b1, 16'd1, 1'b1, '{15'h0000, 15'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_MOVE, 16'h0001, 1'b1, 5'd17, 1'b1, 16'd1, 1'b1, '{15'h0000, 15'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_MOVE, 16'h0000, 1'b1, 5'd5,  1'b0, 16'd1, 1'b1, '{15'h0000, 15'h0010, 1'b0, 1'b1, 1'b0}},
    '{OP_MOVE, 16'h0000, 1'b1, 5'd17, 1'b0, 16'd1, 1'b1, '{15'h0000, 15'h0090, 1'b0, 1'b1, 1'b0}},
    '{OP_MOVE, 16'h0000, 1'b1, 5'd16, 1'b0, 16'd1, 1'b1, '{15'h0000, 15'h00D0, 1'b0, 1'b1, 1'b0}},
    '{OP_MOVE, 16'h0000, 1'b1, 5'd15, 1'b1, 16'd1, 1'b1, '{15'h0000, 15'h40D0, 1'b0, 1'b1, 1'b0}},
    '{OP_MOVE, 16'h0000, 1'b0, 5'd5,  1'b0, 16'd1, 1'b1, '{15'h0000, 15'h40C0, 1'b0, 1'b1, 1'b0}},
    '{OP_MOVE, 16'h0001, 1'b1, 5'd1,  1'b0, 16'd1, 1'b1, '{15'h0000, 15'h40C1, 1'b1, 1'b0, 1'b0}},
    '{OP_MOVE, 16'hFFFF, 1'b1, 5'd2,  1'b0, 16'd1, 1'b1, '{15'h0000, 15'h40C1, 1'b1, 1'b0, 1'b1}},
    '{OP_TICK, 16'h0000, 1'b0, 5'd0,  1'b0, 16'd260, 1'b0, '0},
    '{OP_MOVE, 16'h0000, 1'b1, 5'd13, 1'b0, 16'd1, 1'b1, '{15'h0001, 15'h50C1, 1'b0, 1'b1, 1'b0}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = OP_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // line state as the block should hold it
  logic [PORT_LINES-1:0] step_level = '0;
  logic [PORT_LINES-1:0] dir_level = '0;
  bit                    in_motion = 1'b0;
  bit                    pulse_high = 1'b0;
  int unsigned           half_left = 0;
  int unsigned           half_len = 0;
  int unsigned           pulses_left = 0;
  int                    motion_line = 0;

  line_state_t lines_due[$];
  int          n_errors = 0;
  int          n_items = 0;
  int          tx_run = 0;
  bit          tx_noisy = 1'b0;
  int          rx_run = 0;
  bit          rx_noisy = 1'b0;

  step_dir_pulse_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int draw_gap(inout int run_left, inout bit noisy);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 64);
      noisy = ($urandom_range(0, 9) < 4);
    end
    run_left--;
    return noisy ? $urandom_range(0, 9) : 0;
  endfunction

  function automatic line_state_t advance_lines(op_t op, logic [LEN_W-1:0] len, logic dir,
                                                logic [ACT_W-1:0] act, logic jog);
    line_state_t res;
    int          ln;
    bit          ok;
    int unsigned n;
    int unsigned lenv;
    res = '0;
    lenv = 32'(len);
    if (op == OP_MOVE) begin
      ln = (act >= ACT_FIRST_XTRA) ? int'(act) - int'(XTRA_LINE_OFS) : int'(act) - 1;
      ok = (act >= ACT_FIRST) && (jog ? act <= ACT_LAST_PLAIN : act <= ACT_LAST_XTRA);
      if (ok && ln >= LINE_COUNT) ok = 1'b0;
      if (in_motion || !ok) begin
        res.rej = 1'b1;
      end else begin
        n = (act == ACT_SLOW) ? (25 * lenv) / 2 : (50 * lenv) / 3;
        if (n > (1 << STEP_COUNT_BITS) - 1) n = (1 << STEP_COUNT_BITS) - 1;
        dir_level[ln] = dir;
        motion_line = ln;
        if (n == 0) begin
          res.done = 1'b1;
        end else begin
          pulses_left = n;
          if (jog) half_len = 32'(HALF_JOG);
          else if (act <= ACT_LAST_FAST) half_len = 32'(HALF_FAST);
          else if (act == ACT_SLOW) half_len = 32'(HALF_SLOW);
          else if (act <= ACT_LAST_PLAIN) half_len = 32'(HALF_MID);
          else half_len = 32'(HALF_EXTRA);
          half_left = half_len;
          pulse_high = 1'b0;
          in_motion = 1'b1;
          step_level[ln] = 1'b0;
        end
      end
    end else if (in_motion) begin
      if (half_left > 0) half_left--;
      if (half_left == 0) begin
        if (!pulse_high) begin
          step_level[motion_line] = 1'b1;
          pulse_high = 1'b1;
          half_left = half_len;
        end else begin
          if (pulses_left > 0) pulses_left--;
          if (pulses_left == 0) begin
            in_motion = 1'b0;
            pulse_high = 1'b0;
            res.done = 1'b1;
          end else begin
            step_level[motion_line] = 1'b0;
            pulse_high = 1'b0;
            half_left = half_len;
          end
        end
      end
    end
    res.steps = step_level;
    res.dirs = dir_level;
    res.busy = in_motion;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    n_errors++;
    $display("mismatch at %0t ns: %s got 'h%0h want 'h%0h", $time, what, got, want);
  endtask

  // offer one item, wait for its transfer, then book the result it must cause
  task automatic offer_item(op_t op, logic [LEN_W-1:0] len, logic dir, logic [ACT_W-1:0] act,
                            logic jog, logic typed, line_state_t want);
    int          gap;
    line_state_t calc;
    gap = draw_gap(tx_run, tx_noisy);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, jog, act, dir, len};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_items++;
    calc = advance_lines(op, len, dir, act, jog);
    lines_due.push_back(typed ? want : calc);
  endtask

  // result checker
  always @(posedge clk) begin : watch_results
    line_state_t got;
    line_state_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.steps = m_axis_tdata[14:0];
      got.dirs  = m_axis_tdata[29:15];
      got.busy  = m_axis_tdata[30];
      got.done  = m_axis_tdata[31];
      got.rej   = m_axis_tdata[32];
      if (lines_due.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, 0);
      end else begin
        due = lines_due.pop_front();
        if (got.steps !== due.steps) report_mismatch("step_lines", got.steps, due.steps);
        if (got.dirs !== due.dirs) report_mismatch("dir_lines", got.dirs, due.dirs);
        if (got.busy !== due.busy) report_mismatch("busy_res", got.busy, due.busy);
        if (got.done !== due.done) report_mismatch("done_res", got.done, due.done);
        if (got.rej !== due.rej) report_mismatch("rejected", got.rej, due.rej);
      end
    end
  end

  // result side: random stalls, long hold-offs to fill the block
  initial begin : result_side
    int stall;
    int n_taken;
    n_taken = 0;
    wait (!rst);
    forever begin
      stall = draw_gap(rx_run, rx_noisy);
      if (n_taken == 400 || n_taken == 800) stall = HOLD_CYCLES;
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      n_taken++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int                pick;
    int                v;
    logic [LEN_W-1:0]  len;
    logic [ACT_W-1:0]  act;
    logic              dir;
    logic              jog;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++)
      for (int k = 0; k < PLAN[i].reps; k++)
        offer_item(PLAN[i].op, PLAN[i].len, PLAN[i].dir, PLAN[i].act, PLAN[i].jog,
                   PLAN[i].typed, PLAN[i].want);

    while (n_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 999);
      dir = 1'($urandom_range(0, 1));
      jog = 1'b0;
      if (pick < 10) begin
        // slow actuators, shortest moves only
        v = $urandom_range(0, 2);
        act = (v == 0) ? ACT_SLOW : ACT_W'(15 + v);
        len = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'(1);
      end else if (pick < 40) begin
        jog = 1'b1;
        act = ACT_W'($urandom_range(1, 15));
        len = LEN_W'($urandom_range(0, 1));
      end else if (pick < 130) begin
        // refused actuator numbers, any length
        len = LEN_W'($urandom_range(0, 65535));
        v = $urandom_range(0, 15);
        jog = 1'($urandom_range(0, 1));
        if (v == 0) begin
          act = '0;
        end else if (v < 15) begin
          act = ACT_W'(17 + v);
        end else begin
          act = ACT_W'($urandom_range(16, 17));
          jog = 1'b1;
        end
      end else begin
        act = ACT_W'($urandom_range(1, 14));
        if (act >= ACT_SLOW) act++;
        v = $urandom_range(0, 9);
        len = (v < 3) ? '0 : (v < 8) ? LEN_W'(1) : LEN_W'(2);
      end
      offer_item(OP_MOVE, len, dir, act, jog, 1'b0, '0);
      while (in_motion && n_items < ITEM_TARGET) begin
        if ($urandom_range(0, 99) < 2) begin
          offer_item(OP_MOVE, LEN_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     ACT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          offer_item(OP_TICK, LEN_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     ACT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
      repeat ($urandom_range(0, 3)) begin
        offer_item(OP_TICK, LEN_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                   ACT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sdpg_pkg.sv
hw/rtl/sdpg_cmd_decode.sv
hw/rtl/step_dir_pulse_generator.sv
dv/tb.sv
